>>> rtl/sdh_pkg.sv
package sdh_pkg;

    // String capacity and table geometry.
    localparam int unsigned MAX_LEN     = 4096;
    localparam int unsigned TABLE_DEPTH = MAX_LEN + 1;
    localparam int unsigned IDX_W       = 13;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned H1_W        = 61;
    localparam int unsigned H2_W        = 30;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [H1_W-1:0] MOD_FIRST  = 61'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [H2_W-1:0] MOD_SECOND = 30'd998244353;
    localparam logic [H1_W-1:0] BASE_FIRST_RESET  = 61'd131;
    localparam logic [H2_W-1:0] BASE_SECOND_RESET = 30'd131;

    // Configuration register indexes.
    localparam logic CFG_BASE_FIRST  = 1'b0;
    localparam logic CFG_BASE_SECOND = 1'b1;

    typedef enum logic [1:0] {
        REQ_APPEND  = 2'd0,
        REQ_HASH    = 2'd1,
        REQ_COMPARE = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // What the back end has to do with a classified request.
    typedef enum logic [1:0] {
        K_RESULT  = 2'd0,
        K_APPEND  = 2'd1,
        K_HASH    = 2'd2,
        K_COMPARE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  char_value;
        logic [IDX_W-1:0]   ph0;
        logic [IDX_W-1:0]   pw0;
        logic [IDX_W-1:0]   ph1;
        logic [IDX_W-1:0]   pw1;
        logic [IDX_W-1:0]   end0;
        logic [IDX_W-1:0]   end1;
        t_status            status;
        logic [IDX_W-1:0]   len_after;
    } t_cmd;

    typedef struct packed {
        logic [H1_W-1:0]  hash_first;
        logic [H2_W-1:0]  hash_second;
        logic             match;
        t_status          status;
        logic [IDX_W-1:0] len;
    } t_res;

    // (e - p) mod M for e, p below M.
    function automatic logic [H1_W-1:0] sub_first(input logic [H1_W-1:0] e,
                                                  input logic [H1_W-1:0] p);
        logic [H1_W-1:0] r;
        if (e >= p) begin
            r = e - p;
        end else begin
            r = e + (MOD_FIRST - p);
        end
        return r;
    endfunction

    function automatic logic [H2_W-1:0] sub_second(input logic [H2_W-1:0] e,
                                                   input logic [H2_W-1:0] p);
        logic [H2_W-1:0] r;
        if (e >= p) begin
            r = e - p;
        end else begin
            r = e + (MOD_SECOND - p);
        end
        return r;
    endfunction

endpackage

>>> rtl/substring_double_hash_table.sv
// Double polynomial hash engine over a stored byte string of up to 4096 bytes,
// hashing modulo 2^61-1 and modulo 998244353 with programmable bases. Every
// request transaction (append, substring hash, substring compare, clear)
// returns exactly one result transaction, in request order. A front end checks
// ranges against the current length and queues classified commands; a back end
// reads the prefix-hash and power tables (one read port each) and runs two
// bit-serial modular multipliers side by side. An append, or a hash or compare
// with a good range, is popped by the back end, reads the tables in states
// S_RD0 to S_RD4, runs the multipliers (61 steps, one per bit of the 61-bit
// operand, until both finish) and has its result registered in the finishing
// state; clears and rejected requests go from the pop straight to that state.
// A stalled result holds the back end there. One request is worked at a time;
// up to QUEUE_DEPTH more (two by default) are held in the command queue. The
// user must write bases through the configuration port only while no request
// is outstanding; the block does not enforce this. A base at or above its
// modulus is reduced. No clearing pass follows reset.
module substring_double_hash_table #(
    parameter int unsigned QUEUE_DEPTH = sdh_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Request channel.
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_req_type,
    input  logic [sdh_pkg::CHAR_W-1:0]  i_char_value,
    input  logic [sdh_pkg::IDX_W-1:0]   i_first_start,
    input  logic [sdh_pkg::IDX_W-1:0]   i_first_end,
    input  logic [sdh_pkg::IDX_W-1:0]   i_second_start,
    input  logic [sdh_pkg::IDX_W-1:0]   i_second_end,
    // Result channel.
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sdh_pkg::H1_W-1:0]    o_hash_first_mod,
    output logic [sdh_pkg::H2_W-1:0]    o_hash_second_mod,
    output logic                        o_match_flag,
    output logic [1:0]                  o_status,
    output logic [sdh_pkg::IDX_W-1:0]   o_current_length,
    // Configuration write channel.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [sdh_pkg::H1_W-1:0]    i_cfg_data
);
    logic [sdh_pkg::H1_W-1:0] r_base_first, eff_first;
    logic [sdh_pkg::H2_W-1:0] r_base_second, eff_second;

    logic          push, full, pop, empty;
    sdh_pkg::t_cmd cmd_in, cmd_out;
    sdh_pkg::t_res res;

    // The configuration port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_first  <= sdh_pkg::BASE_FIRST_RESET;
            r_base_second <= sdh_pkg::BASE_SECOND_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sdh_pkg::CFG_BASE_FIRST:  r_base_first  <= i_cfg_data;
                sdh_pkg::CFG_BASE_SECOND: r_base_second <= i_cfg_data[sdh_pkg::H2_W-1:0];
                default:                  r_base_first  <= r_base_first;
            endcase
        end
    end

    // Only the all-ones pattern reaches 2^61-1; the 30-bit base is below
    // twice 998244353, so one subtraction reduces either.
    assign eff_first  = (r_base_first == sdh_pkg::MOD_FIRST) ? '0 : r_base_first;
    assign eff_second = (r_base_second >= sdh_pkg::MOD_SECOND)
                      ? r_base_second - sdh_pkg::MOD_SECOND : r_base_second;

    sdh_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_char_value(i_char_value),
        .i_first_start(i_first_start), .i_first_end(i_first_end),
        .i_second_start(i_second_start), .i_second_end(i_second_end),
        .o_push(push), .o_cmd(cmd_in), .i_full(full));

    sdh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(cmd_in), .o_full(full),
        .i_pop(pop), .o_data(cmd_out), .o_empty(empty));

    sdh_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(empty), .o_pop(pop), .i_cmd(cmd_out),
        .i_base_first(eff_first), .i_base_second(eff_second),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(res));

    assign o_hash_first_mod  = res.hash_first;
    assign o_hash_second_mod = res.hash_second;
    assign o_match_flag      = res.match;
    assign o_status          = res.status;
    assign o_current_length  = res.len;
endmodule

>>> rtl/sdh_ram.sv
module sdh_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/sdh_queue.sv
module sdh_queue #(
    parameter int unsigned DEPTH = sdh_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sdh_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output sdh_pkg::t_cmd o_data,
    output logic          o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sdh_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

>>> rtl/sdh_front.sv
module sdh_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_req_type,
    input  logic [sdh_pkg::CHAR_W-1:0]  i_char_value,
    input  logic [sdh_pkg::IDX_W-1:0]   i_first_start,
    input  logic [sdh_pkg::IDX_W-1:0]   i_first_end,
    input  logic [sdh_pkg::IDX_W-1:0]   i_second_start,
    input  logic [sdh_pkg::IDX_W-1:0]   i_second_end,
    output logic                        o_push,
    output sdh_pkg::t_cmd               o_cmd,
    input  logic                        i_full
);
    // The front end owns the string length, so each request is checked
    // against the length left by every request accepted before it.
    logic [sdh_pkg::IDX_W-1:0] r_len, n_len;
    logic [sdh_pkg::IDX_W-1:0] len1, len2;
    logic                      ok1, ok2;
    sdh_pkg::t_cmd             cmd;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_cmd   = cmd;

    assign ok1  = (i_first_start <= i_first_end) && (i_first_end <= r_len);
    assign ok2  = (i_second_start <= i_second_end) && (i_second_end <= r_len);
    assign len1 = i_first_end - i_first_start;
    assign len2 = i_second_end - i_second_start;

    always_comb begin
        cmd            = '0;
        cmd.kind       = sdh_pkg::K_RESULT;
        cmd.status     = sdh_pkg::ST_OK;
        cmd.char_value = i_char_value;
        cmd.len_after  = r_len;
        n_len          = r_len;
        unique case (i_req_type)
            sdh_pkg::REQ_APPEND: begin
                if (r_len >= sdh_pkg::IDX_W'(sdh_pkg::MAX_LEN)) begin
                    cmd.status = sdh_pkg::ST_FULL;
                end else begin
                    cmd.kind      = sdh_pkg::K_APPEND;
                    cmd.ph0       = r_len;
                    cmd.pw0       = r_len;
                    cmd.ph1       = r_len;
                    cmd.pw1       = r_len;
                    cmd.end0      = r_len;
                    cmd.end1      = r_len;
                    n_len         = r_len + 1'b1;
                    cmd.len_after = n_len;
                end
            end
            sdh_pkg::REQ_HASH: begin
                if (ok1) begin
                    cmd.kind = sdh_pkg::K_HASH;
                    cmd.ph0  = i_first_start;
                    cmd.pw0  = len1;
                    cmd.ph1  = i_first_start;
                    cmd.pw1  = len1;
                    cmd.end0 = i_first_end;
                    cmd.end1 = i_first_end;
                end else begin
                    cmd.status = sdh_pkg::ST_RANGE;
                end
            end
            sdh_pkg::REQ_COMPARE: begin
                if (ok1 && ok2) begin
                    cmd.kind = sdh_pkg::K_COMPARE;
                    cmd.ph0  = i_first_start;
                    cmd.pw0  = len1;
                    cmd.ph1  = i_second_start;
                    cmd.pw1  = len2;
                    cmd.end0 = i_first_end;
                    cmd.end1 = i_second_end;
                end else begin
                    cmd.status = sdh_pkg::ST_RANGE;
                end
            end
            sdh_pkg::REQ_CLEAR: begin
                n_len         = '0;
                cmd.len_after = '0;
            end
            default: begin
                cmd.status = sdh_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (o_push) begin
            r_len <= n_len;
        end
    end
endmodule

>>> rtl/sdh_modmul.sv
module sdh_modmul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sdh_pkg::H1_W-1:0]  i_a1,
    input  logic [sdh_pkg::H1_W-1:0]  i_b1,
    input  logic [sdh_pkg::H2_W-1:0]  i_a2,
    input  logic [sdh_pkg::H2_W-1:0]  i_b2,
    output logic                      o_busy,
    output logic [sdh_pkg::H1_W-1:0]  o_p1,
    output logic [sdh_pkg::H2_W-1:0]  o_p2
);
    // Bit-serial double-and-add over the multiplier bits, MSB first, for
    // both moduli side by side. The second multiplier is zero-extended.
    localparam int unsigned STEPS = sdh_pkg::H1_W;
    localparam int unsigned CNT_W = $clog2(STEPS);
    localparam int unsigned W1    = sdh_pkg::H1_W;
    localparam int unsigned W2    = sdh_pkg::H2_W;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W1-1:0]    r_a1, r_b1, r_acc1;
    logic [W2-1:0]    r_a2, r_acc2;
    logic [W1-1:0]    r_b2;

    logic [W1-1:0] rot1, step1;
    logic [W1:0]   s1;
    logic [W2:0]   d2, s2;
    logic [W2-1:0] step2;

    always_comb begin
        // Doubling modulo 2^61-1 is a rotate by one bit.
        rot1 = {r_acc1[W1-2:0], r_acc1[W1-1]};
        s1   = {1'b0, rot1} + {1'b0, (r_b1[W1-1] ? r_a1 : '0)};
        if (s1 >= {1'b0, sdh_pkg::MOD_FIRST}) begin
            s1 = s1 - {1'b0, sdh_pkg::MOD_FIRST};
        end
        step1 = s1[W1-1:0];

        d2 = {r_acc2, 1'b0};
        if (d2 >= {1'b0, sdh_pkg::MOD_SECOND}) begin
            d2 = d2 - {1'b0, sdh_pkg::MOD_SECOND};
        end
        s2 = d2 + {1'b0, (r_b2[W1-1] ? r_a2 : '0)};
        if (s2 >= {1'b0, sdh_pkg::MOD_SECOND}) begin
            s2 = s2 - {1'b0, sdh_pkg::MOD_SECOND};
        end
        step2 = s2[W2-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a1   <= i_a1;
            r_b1   <= i_b1;
            r_a2   <= i_a2;
            r_b2   <= W1'(i_b2);
            r_acc1 <= '0;
            r_acc2 <= '0;
        end else if (r_busy) begin
            r_acc1 <= step1;
            r_acc2 <= step2;
            r_b1   <= {r_b1[W1-2:0], 1'b0};
            r_b2   <= {r_b2[W1-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_p1   = r_acc1;
    assign o_p2   = r_acc2;
endmodule

>>> rtl/sdh_back.sv
module sdh_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    output logic                      o_pop,
    input  sdh_pkg::t_cmd             i_cmd,
    input  logic [sdh_pkg::H1_W-1:0]  i_base_first,
    input  logic [sdh_pkg::H2_W-1:0]  i_base_second,
    output logic                      o_valid,
    input  logic                      i_ready,
    output sdh_pkg::t_res             o_res
);
    localparam int unsigned W1 = sdh_pkg::H1_W;
    localparam int unsigned W2 = sdh_pkg::H2_W;
    localparam int unsigned AW = $clog2(sdh_pkg::TABLE_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD0  = 8'b0000_0010,
        S_RD1  = 8'b0000_0100,
        S_RD2  = 8'b0000_1000,
        S_RD3  = 8'b0001_0000,
        S_RD4  = 8'b0010_0000,
        S_MUL  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state        r_state, n_state;
    sdh_pkg::t_cmd r_cmd;

    logic [AW-1:0] ph_raddr, pw_raddr, waddr;
    logic          r_ph_zero, r_pw_zero;
    logic [W1-1:0] ph1_q, pw1_q, ph1_rd, pw1_rd, ph1_new;
    logic [W2-1:0] ph2_q, pw2_q, ph2_rd, pw2_rd, ph2_new;
    logic          we;

    logic [W1-1:0] r_xa1, r_ya1, r_xb1, r_yb1, r_ea1, r_eb1;
    logic [W2-1:0] r_xa2, r_ya2, r_xb2, r_yb2, r_ea2, r_eb2;

    logic          mul_start, busy_a, busy_b, is_app;
    logic [W1-1:0] pa1, pb1, ha1, hb1;
    logic [W2-1:0] pa2, pb2, ha2, hb2;
    logic [W1:0]   sum1;
    logic [W2:0]   sum2;

    logic          r_out_valid, out_free;
    sdh_pkg::t_res r_out, res;

    assign is_app   = (r_cmd.kind == sdh_pkg::K_APPEND);
    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign mul_start = (r_state == S_RD4);

    // Read address sequence: start/power pairs first, then the two ends.
    always_comb begin
        ph_raddr = AW'(r_cmd.ph0);
        pw_raddr = AW'(r_cmd.pw0);
        unique case (r_state)
            S_RD1: begin
                ph_raddr = AW'(r_cmd.ph1);
                pw_raddr = AW'(r_cmd.pw1);
            end
            S_RD2: ph_raddr = AW'(r_cmd.end0);
            S_RD3: ph_raddr = AW'(r_cmd.end1);
            default: begin
                ph_raddr = AW'(r_cmd.ph0);
            end
        endcase
    end

    // Entry zero of every table is fixed and never written.
    assign ph1_rd = r_ph_zero ? '0 : ph1_q;
    assign ph2_rd = r_ph_zero ? '0 : ph2_q;
    assign pw1_rd = r_pw_zero ? W1'(1) : pw1_q;
    assign pw2_rd = r_pw_zero ? W2'(1) : pw2_q;

    assign we    = (r_state == S_FIN) && out_free && is_app;
    assign waddr = AW'(r_cmd.ph0) + 1'b1;

    sdh_ram #(.WIDTH(W1), .DEPTH(sdh_pkg::TABLE_DEPTH)) u_ph1 (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(ph1_new),
        .i_raddr(ph_raddr), .o_rdata(ph1_q));
    sdh_ram #(.WIDTH(W2), .DEPTH(sdh_pkg::TABLE_DEPTH)) u_ph2 (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(ph2_new),
        .i_raddr(ph_raddr), .o_rdata(ph2_q));
    sdh_ram #(.WIDTH(W1), .DEPTH(sdh_pkg::TABLE_DEPTH)) u_pw1 (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(pb1),
        .i_raddr(pw_raddr), .o_rdata(pw1_q));
    sdh_ram #(.WIDTH(W2), .DEPTH(sdh_pkg::TABLE_DEPTH)) u_pw2 (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(pb2),
        .i_raddr(pw_raddr), .o_rdata(pw2_q));

    // Lane A: prefix times base on append, start-prefix times power on a query.
    // Lane B: power times base on append, the second substring on a compare.
    sdh_modmul u_mul_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a1(r_xa1), .i_b1(is_app ? i_base_first : r_ya1),
        .i_a2(r_xa2), .i_b2(is_app ? i_base_second : r_ya2),
        .o_busy(busy_a), .o_p1(pa1), .o_p2(pa2));
    sdh_modmul u_mul_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a1(is_app ? r_ya1 : r_xb1), .i_b1(is_app ? i_base_first : r_yb1),
        .i_a2(is_app ? r_ya2 : r_xb2), .i_b2(is_app ? i_base_second : r_yb2),
        .o_busy(busy_b), .o_p1(pb1), .o_p2(pb2));

    always_comb begin
        sum1 = {1'b0, pa1} + {{(W1 + 1 - sdh_pkg::CHAR_W){1'b0}}, r_cmd.char_value};
        if (sum1 >= {1'b0, sdh_pkg::MOD_FIRST}) begin
            sum1 = sum1 - {1'b0, sdh_pkg::MOD_FIRST};
        end
        ph1_new = sum1[W1-1:0];
        sum2 = {1'b0, pa2} + {{(W2 + 1 - sdh_pkg::CHAR_W){1'b0}}, r_cmd.char_value};
        if (sum2 >= {1'b0, sdh_pkg::MOD_SECOND}) begin
            sum2 = sum2 - {1'b0, sdh_pkg::MOD_SECOND};
        end
        ph2_new = sum2[W2-1:0];
    end

    assign ha1 = sdh_pkg::sub_first(r_ea1, pa1);
    assign hb1 = sdh_pkg::sub_first(r_eb1, pb1);
    assign ha2 = sdh_pkg::sub_second(r_ea2, pa2);
    assign hb2 = sdh_pkg::sub_second(r_eb2, pb2);

    always_comb begin
        res        = '0;
        res.status = r_cmd.status;
        res.len    = r_cmd.len_after;
        unique case (r_cmd.kind)
            sdh_pkg::K_HASH: begin
                res.hash_first  = ha1;
                res.hash_second = ha2;
            end
            sdh_pkg::K_COMPARE: begin
                res.hash_first  = ha1;
                res.hash_second = ha2;
                res.match       = (ha1 == hb1) && (ha2 == hb2);
            end
            default: begin
                res.match = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_cmd.kind == sdh_pkg::K_RESULT) ? S_FIN : S_RD0;
                end
            end
            S_RD0: n_state = S_RD1;
            S_RD1: n_state = S_RD2;
            S_RD2: n_state = S_RD3;
            S_RD3: n_state = S_RD4;
            S_RD4: n_state = S_MUL;
            S_MUL: begin
                if (!busy_a && !busy_b) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ph_zero <= (ph_raddr == '0);
        r_pw_zero <= (pw_raddr == '0);
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_RD1) begin
            r_xa1 <= ph1_rd;
            r_xa2 <= ph2_rd;
            r_ya1 <= pw1_rd;
            r_ya2 <= pw2_rd;
        end
        if (r_state == S_RD2) begin
            r_xb1 <= ph1_rd;
            r_xb2 <= ph2_rd;
            r_yb1 <= pw1_rd;
            r_yb2 <= pw2_rd;
        end
        if (r_state == S_RD3) begin
            r_ea1 <= ph1_rd;
            r_ea2 <= ph2_rd;
        end
        if (r_state == S_RD4) begin
            r_eb1 <= ph1_rd;
            r_eb2 <= ph2_rd;
        end
        if ((r_state == S_FIN) && out_free) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
endmodule

>>> rtl/sdh_checker.sv
module sdh_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [sdh_pkg::H1_W-1:0]  o_hash_first_mod,
    input logic [sdh_pkg::H2_W-1:0]  o_hash_second_mod,
    input logic                      o_match_flag,
    input logic [1:0]                o_status,
    input logic [sdh_pkg::IDX_W-1:0] o_current_length
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hash_first_mod)
            && $stable(o_hash_second_mod) && $stable(o_status)
            && $stable(o_current_length))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != sdh_pkg::ST_OK) |-> (o_hash_first_mod == '0)
            && (o_hash_second_mod == '0) && !o_match_flag)
        else $error("error result carries hash data");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_current_length <= sdh_pkg::IDX_W'(sdh_pkg::MAX_LEN))
        else $error("length beyond capacity");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == sdh_pkg::ST_FULL)
            |-> o_current_length == sdh_pkg::IDX_W'(sdh_pkg::MAX_LEN))
        else $error("full status with string not full");
endmodule

bind substring_double_hash_table sdh_checker u_sdh_checker (.*);
